FILE: hw/rtl/memory_card_three_wire_host_top_defines.svh
// Assertion helpers for the three-wire card host checker.
// Both macros expect clk and rst to be visible where they are used.
`ifndef MEMORY_CARD_THREE_WIRE_HOST_TOP_DEFINES_SVH
`define MEMORY_CARD_THREE_WIRE_HOST_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define MCTH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MCTH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mcth_pkg.sv
// ----------------------------------------------------------------------------
// mcth_pkg
// Shared types, command constants and helpers for the three-wire card host.
// ----------------------------------------------------------------------------
`default_nettype none

package mcth_pkg;

  localparam int ADDR_WIDTH = 10;
  localparam logic [9:0] ADDR_MASK = 10'((1 << ADDR_WIDTH) - 1);

  // Operation codes
  localparam logic [2:0] OP_ANSWER  = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_READ_PB = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_VERIFY  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_BAD_PIN = 2'd2;

  // Command bytes
  localparam logic [7:0] CMD_READ     = 8'h0E;
  localparam logic [7:0] CMD_READ_PB  = 8'h0C;
  localparam logic [7:0] CMD_WRITE    = 8'h33;
  localparam logic [7:0] CMD_WR_ERR   = 8'hF2;
  localparam logic [7:0] CMD_CMP      = 8'hCD;
  localparam logic [7:0] CMD_ERASE    = 8'hF3;
  localparam logic [7:0] ERR_ADDR_LO  = 8'hFD;
  localparam logic [7:0] PIN1_ADDR_LO = 8'hFE;
  localparam logic [7:0] PIN2_ADDR_LO = 8'hFF;
  localparam logic [7:0] ERASE_DATA   = 8'h7F;
  localparam logic [7:0] ERR_MASK     = 8'h7E;
  localparam logic [9:0] ERR_ADDR     = 10'd1021;
  localparam logic [7:0] WRITE_CLKS   = 8'd203;
  localparam logic [7:0] VERIFY_CLKS  = 8'd103;

  typedef struct packed {
    logic        card_present;
    logic        data_line_in;
    logic [7:0]  psc_second;
    logic [7:0]  psc_first;
    logic [10:0] byte_count;
    logic [7:0]  write_data;
    logic [9:0]  address;
    logic [2:0]  op;
    logic        kind;
  } item_t;

  typedef struct packed {
    logic       busy_res;
    logic       card_on;
    logic [7:0] tries_left;
    logic [1:0] status;
    logic       done_res;
    logic       rx_valid;
    logic       rx_protect;
    logic [7:0] rx_byte;
    logic       data_out;
    logic       reset_out;
    logic       clock_out;
  } res_t;

  // 24-bit command word, sent LSB first
  function automatic logic [23:0] make_cmd(input logic [9:0] a, input logic [7:0] base,
                                           input logic [7:0] third);
    logic [7:0] b0;
    b0 = {a[9:8], 6'b0} | base;
    return {third, a[7:0], b0};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/memory_card_three_wire_host_top.sv
// ----------------------------------------------------------------------------
// memory_card_three_wire_host_top
// Host sequencer for a three-wire memory card, one result per input item.
// ----------------------------------------------------------------------------
// An accepted item passes the input register, then the result register, to result valid.
// Throughput: 1 item per cycle unless m_tready holds the output; each item is one combinational sequencer step.
// Reset (rst, synchronous): idle, pins clock 0 reset 0 data 1, delay_ticks 1.
// Configuration writes are always accepted (cfg_ready high).
`default_nettype none

module memory_card_three_wire_host_top import mcth_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,     // delay_ticks
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // op, address, write_data, byte_count, psc_first, psc_second, data_line_in,
  // card_present
  input  wire logic [55:0] s_tdata,
  input  wire logic [0:0]  s_tuser,      // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // clock_out, reset_out, data_out, rx_byte, rx_protect, rx_valid, done_res,
  // status, tries_left, card_on, busy_res
  output logic [31:0]      m_tdata
);

  logic [7:0] delay_ticks;
  item_t      in_item;
  item_t      q_item;
  logic       q_valid;
  logic       advance;
  logic       fire;
  res_t       res;

  assign cfg_ready = 1'b1;
  assign in_item   = {s_tdata[49:0], s_tuser[0]};
  assign m_tdata   = {6'd0, res};

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= 8'd1;
    end else if (cfg_valid) begin
      delay_ticks <= cfg_data;
    end
  end

  mcth_in_stage u_in (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_item(in_item), .advance(advance), .q_valid(q_valid), .q_item(q_item)
  );

  mcth_seq u_seq (
    .clk(clk), .rst(rst), .delay_ticks(delay_ticks), .fire(fire),
    .item(q_item), .res(res)
  );

  mcth_out_stage u_out (
    .clk(clk), .rst(rst), .q_valid(q_valid), .out_ready(m_tready),
    .advance(advance), .fire(fire), .out_valid(m_tvalid)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/mcth_in_stage.sv
// ----------------------------------------------------------------------------
// mcth_in_stage
// Input register: holds one accepted item until the sequencer consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mcth_in_stage import mcth_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       q_valid,
  output item_t      q_item
);

  assign in_ready = !q_valid || advance;

  // control bit
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_item <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mcth_seq.sv
// ----------------------------------------------------------------------------
// mcth_seq
// Pin sequencer: state registers plus one combinational step per item.
// ----------------------------------------------------------------------------
`default_nettype none

module mcth_seq import mcth_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] delay_ticks,
  input  wire logic       fire,
  input  wire item_t      item,
  output res_t            res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_SC0, PH_SC1, PH_SC2, PH_SC3, PH_SC4, PH_SCEND,
    PH_SEND0, PH_SEND1, PH_SEND2, PH_SBIT, PH_SEND3, PH_SEND4, PH_SEND5,
    PH_RD1, PH_RBYTE, PH_RBIT, PH_RD2, PH_RD3, PH_PB1, PH_PB2, PH_RDEND,
    PH_ABYTE, PH_ABIT, PH_AT1, PH_AT2, PH_PR1, PH_PR2, PH_PR3, PH_PR4, PH_PRDONE
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [23:0] cmd;
    logic [4:0]  bit_cnt;
    logic [10:0] byte_cnt;
    logic [7:0]  rx_shift;
    logic [7:0]  delay_cnt;
    logic [7:0]  proc_cnt;
    logic [7:0]  saved_err;
    logic        pin_index;
    logic [2:0]  op;
    logic [10:0] byte_count;
    logic [7:0]  psc_first;
    logic [7:0]  psc_second;
    logic [2:0]  stage;
    logic [7:0]  proc_limit;
    logic        pin_clk;
    logic        pin_rst;
    logic        pin_dio;
  } seq_state_t;

  localparam int STEPS = 6;

  seq_state_t cur;
  seq_state_t cur_next;
  res_t       res_next;

  // one item: start load or delay counting, then up to STEPS chained phase steps until a pin step or the end
  always_comb begin
    logic       active;
    logic [8:0] cnt;
    logic [8:0] lim;
    logic [9:0] a;
    logic       s;
    cur_next = cur;
    res_next = '0;
    active   = 1'b0;
    s        = item.data_line_in;
    a        = item.address & ADDR_MASK;
    cnt      = {1'b0, cur.delay_cnt} + 9'd1;
    lim      = {1'b0, (delay_ticks == 8'd0) ? 8'd1 : delay_ticks};

    if (item.kind) begin
      if (cur.phase == PH_IDLE && item.op <= OP_VERIFY) begin
        cur_next.op         = item.op;
        cur_next.byte_count = item.byte_count;
        cur_next.psc_first  = item.psc_first;
        cur_next.psc_second = item.psc_second;
        cur_next.stage      = 3'd0;
        cur_next.proc_limit = 8'd0;
        cur_next.pin_index  = 1'b0;
        cur_next.saved_err  = 8'd0;
        cur_next.byte_cnt   = 11'd0;
        case (item.op)
          OP_ANSWER:  cur_next.cmd = 24'd0;
          OP_READ:    cur_next.cmd = make_cmd(a, CMD_READ, 8'd0);
          OP_READ_PB: cur_next.cmd = make_cmd(a, CMD_READ_PB, 8'd0);
          OP_WRITE:   cur_next.cmd = make_cmd(a, CMD_WRITE, item.write_data);
          default: begin
            cur_next.byte_count = 11'd1;
            cur_next.cmd        = make_cmd(ERR_ADDR, CMD_READ, 8'd0);
          end
        endcase
        cur_next.phase = PH_SC0;
        active = 1'b1;
      end
    end else if (cur.phase != PH_IDLE) begin
      cur_next.delay_cnt = cnt[7:0];
      if (cnt >= lim) active = 1'b1;
    end

    for (int i = 0; i < STEPS; i++) begin
      if (active) begin
        case (cur_next.phase)
          PH_SC0: begin
            cur_next.pin_clk = 1'b0; cur_next.pin_rst = 1'b0;
            cur_next.phase = PH_SC1; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_SC1: begin
            cur_next.pin_rst = 1'b1;
            cur_next.phase = PH_SC2; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_SC2: begin
            cur_next.pin_clk = 1'b1;
            cur_next.phase = PH_SC3; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_SC3: begin
            cur_next.pin_clk = 1'b0;
            cur_next.phase = PH_SC4; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_SC4: begin
            cur_next.pin_rst = 1'b0; cur_next.pin_dio = 1'b1;
            cur_next.phase = PH_SCEND; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_SCEND: begin
            cur_next.byte_cnt = 11'd0;
            cur_next.phase = (cur_next.op == OP_ANSWER) ? PH_ABYTE : PH_SEND0;
          end
          PH_SEND0: begin
            cur_next.pin_dio = 1'b1;
            cur_next.phase = PH_SEND1; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_SEND1: begin
            cur_next.pin_rst = 1'b1;
            cur_next.phase = PH_SEND2; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_SEND2: begin
            cur_next.pin_clk = 1'b0; cur_next.bit_cnt = 5'd0;
            cur_next.phase = PH_SBIT;
          end
          PH_SBIT: begin
            cur_next.pin_dio = cur_next.cmd[cur_next.bit_cnt];
            cur_next.phase = PH_SEND3; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_SEND3: begin
            cur_next.pin_clk = 1'b1;
            cur_next.phase = PH_SEND4; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_SEND4: begin
            cur_next.pin_clk = 1'b0;
            cur_next.bit_cnt = cur_next.bit_cnt + 5'd1;
            if (cur_next.bit_cnt < 5'd24) begin
              cur_next.phase = PH_SBIT;
            end else begin
              cur_next.phase = PH_SEND5; cur_next.delay_cnt = 8'd0; active = 1'b0;
            end
          end
          PH_SEND5: begin
            cur_next.pin_rst = 1'b0;
            if (cur_next.op == OP_WRITE || (cur_next.op == OP_VERIFY &&
                cur_next.stage >= 3'd1 && cur_next.stage <= 3'd3)) begin
              cur_next.proc_limit = (cur_next.op == OP_WRITE) ? WRITE_CLKS : VERIFY_CLKS;
              cur_next.phase = PH_PR1;
            end else begin
              cur_next.phase = PH_RD1;
            end
            cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_RD1: begin
            cur_next.pin_clk = 1'b1; cur_next.byte_cnt = 11'd0;
            cur_next.phase = PH_RBYTE;
          end
          PH_RBYTE: begin
            if (cur_next.byte_cnt >= cur_next.byte_count) begin
              cur_next.phase = PH_RDEND; cur_next.delay_cnt = 8'd0; active = 1'b0;
            end else begin
              cur_next.pin_dio = 1'b1; cur_next.bit_cnt = 5'd0;
              cur_next.rx_shift = 8'd0;
              cur_next.phase = PH_RBIT;
            end
          end
          PH_RBIT: begin
            cur_next.rx_shift = cur_next.rx_shift >> 1;
            cur_next.pin_clk = 1'b0;
            cur_next.phase = PH_RD2; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_RD2: begin
            cur_next.pin_clk = 1'b1;
            cur_next.phase = PH_RD3; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_RD3: begin
            cur_next.rx_shift = {s, cur_next.rx_shift[6:0]};
            cur_next.bit_cnt = cur_next.bit_cnt + 5'd1;
            if (cur_next.bit_cnt < 5'd8) begin
              cur_next.phase = PH_RBIT;
            end else if (cur_next.op == OP_READ_PB) begin
              cur_next.pin_clk = 1'b0;
              cur_next.phase = PH_PB1; cur_next.delay_cnt = 8'd0; active = 1'b0;
            end else begin
              if (cur_next.op != OP_VERIFY) begin
                res_next.rx_valid = 1'b1; res_next.rx_byte = cur_next.rx_shift;
                res_next.rx_protect = 1'b0;
              end
              cur_next.byte_cnt = cur_next.byte_cnt + 11'd1;
              cur_next.phase = PH_RBYTE;
            end
          end
          PH_PB1: begin
            cur_next.pin_clk = 1'b1;
            cur_next.phase = PH_PB2; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_PB2: begin
            if (cur_next.op != OP_VERIFY) begin
              res_next.rx_valid = 1'b1; res_next.rx_byte = cur_next.rx_shift;
              res_next.rx_protect = s;
            end
            cur_next.byte_cnt = cur_next.byte_cnt + 11'd1;
            cur_next.phase = PH_RBYTE;
          end
          PH_RDEND: begin
            cur_next.pin_clk = 1'b0;
            if (cur_next.op != OP_VERIFY) begin
              cur_next.phase = PH_IDLE; res_next.done_res = 1'b1;
              res_next.status = ST_OK; active = 1'b0;
            end else if (cur_next.stage == 3'd0) begin
              if (cur_next.rx_shift == 8'd0) begin
                cur_next.phase = PH_IDLE; res_next.done_res = 1'b1;
                res_next.status = ST_BLOCKED; active = 1'b0;
              end else begin
                cur_next.saved_err = {cur_next.rx_shift[6:0], 1'b0} & ERR_MASK;
                cur_next.cmd = {cur_next.saved_err, ERR_ADDR_LO, CMD_WR_ERR};
                cur_next.stage = 3'd1;
                cur_next.phase = PH_SC0;
              end
            end else begin
              cur_next.phase = PH_IDLE; res_next.done_res = 1'b1; active = 1'b0;
              if (cur_next.rx_shift == cur_next.saved_err) begin
                res_next.status = ST_BAD_PIN; res_next.tries_left = cur_next.saved_err;
              end else begin
                res_next.status = ST_OK;
              end
            end
          end
          PH_ABYTE: begin
            if (cur_next.byte_cnt >= 11'd4) begin
              cur_next.phase = PH_IDLE; res_next.done_res = 1'b1;
              res_next.status = ST_OK; active = 1'b0;
            end else begin
              cur_next.rx_shift = 8'd0; cur_next.bit_cnt = 5'd0;
              cur_next.phase = PH_ABIT;
            end
          end
          PH_ABIT: begin
            cur_next.rx_shift = cur_next.rx_shift >> 1;
            cur_next.pin_clk = 1'b1;
            cur_next.phase = PH_AT1; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_AT1: begin
            cur_next.rx_shift = {s, cur_next.rx_shift[6:0]};
            cur_next.pin_clk = 1'b0;
            if (cur_next.bit_cnt == 5'd7 && cur_next.op != OP_VERIFY) begin
              res_next.rx_valid = 1'b1; res_next.rx_byte = cur_next.rx_shift;
              res_next.rx_protect = 1'b0;
            end
            cur_next.bit_cnt = cur_next.bit_cnt + 5'd1;
            cur_next.phase = PH_AT2; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_AT2: begin
            if (cur_next.bit_cnt < 5'd8) begin
              cur_next.phase = PH_ABIT;
            end else begin
              cur_next.byte_cnt = cur_next.byte_cnt + 11'd1;
              cur_next.phase = PH_ABYTE;
            end
          end
          PH_PR1: begin
            cur_next.pin_clk = 1'b0; cur_next.pin_dio = 1'b1; cur_next.proc_cnt = 8'd0;
            cur_next.phase = PH_PR2; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_PR2: begin
            if (cur_next.proc_cnt >= cur_next.proc_limit) begin
              cur_next.phase = PH_PRDONE;
            end else begin
              cur_next.pin_clk = 1'b1;
              cur_next.phase = PH_PR3; cur_next.delay_cnt = 8'd0; active = 1'b0;
            end
          end
          PH_PR3: begin
            cur_next.pin_clk = 1'b0;
            cur_next.phase = PH_PR4; cur_next.delay_cnt = 8'd0; active = 1'b0;
          end
          PH_PR4: begin
            // card pulls the line low when it is done early
            if (!s) begin
              cur_next.phase = PH_PRDONE;
            end else begin
              cur_next.proc_cnt = cur_next.proc_cnt + 8'd1;
              cur_next.phase = PH_PR2;
            end
          end
          PH_PRDONE: begin
            if (cur_next.op != OP_VERIFY) begin
              cur_next.phase = PH_IDLE; res_next.done_res = 1'b1;
              res_next.status = ST_OK; active = 1'b0;
            end else begin
              if (cur_next.stage == 3'd1) begin
                cur_next.stage = 3'd2; cur_next.pin_index = 1'b0;
                cur_next.cmd = {cur_next.psc_first, PIN1_ADDR_LO, CMD_CMP};
              end else if (cur_next.stage == 3'd2 && !cur_next.pin_index) begin
                cur_next.pin_index = 1'b1;
                cur_next.cmd = {cur_next.psc_second, PIN2_ADDR_LO, CMD_CMP};
              end else if (cur_next.stage == 3'd2) begin
                cur_next.stage = 3'd3;
                cur_next.cmd = {ERASE_DATA, ERR_ADDR_LO, CMD_ERASE};
              end else begin
                cur_next.stage = 3'd4;
                cur_next.byte_count = 11'd1;
                cur_next.cmd = make_cmd(ERR_ADDR, CMD_READ, 8'd0);
              end
              cur_next.phase = PH_SC0;
            end
          end
          default: begin
            cur_next.phase = PH_IDLE; active = 1'b0;
          end
        endcase
      end
    end

    res_next.clock_out = cur_next.pin_clk;
    res_next.reset_out = cur_next.pin_rst;
    res_next.data_out  = cur_next.pin_dio;
    res_next.card_on   = item.card_present;
    res_next.busy_res  = (cur_next.phase != PH_IDLE);
  end

  // state and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      cur         <= '0;
      cur.phase   <= PH_IDLE;
      cur.pin_dio <= 1'b1;
    end else if (fire) begin
      cur <= cur_next;
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mcth_out_stage.sv
// ----------------------------------------------------------------------------
// mcth_out_stage
// Output valid tracking; the result register itself sits in the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mcth_out_stage import mcth_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire logic out_ready,
  output logic      advance,
  output logic      fire,
  output logic      out_valid
);

  assign advance = !out_valid || out_ready;
  assign fire    = q_valid && advance;

  // a result is pending from the fire until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= q_valid;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mcth_checker.sv
// ----------------------------------------------------------------------------
// mcth_checker
// Port-level checks on the result stream of the card host.
// ----------------------------------------------------------------------------
`default_nettype none
`include "memory_card_three_wire_host_top_defines.svh"

module mcth_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [7:0]  cfg_data,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [55:0] s_tdata,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // finishing an operation leaves the block idle
  `MCTH_ASSERT_IMP(a_done_idle, m_tvalid && m_tdata[13], !m_tdata[25], "done while busy")

  // status and tries only carry meaning on a done result
  `MCTH_ASSERT_IMP(a_status_quiet, m_tvalid && !m_tdata[13],
                   m_tdata[15:14] == 2'd0 && m_tdata[23:16] == 8'd0, "status without done")

  // received byte fields are zero when no byte is reported
  `MCTH_ASSERT_IMP(a_rx_quiet, m_tvalid && !m_tdata[12],
                   m_tdata[10:3] == 8'd0 && !m_tdata[11], "rx data without rx_valid")

  // a stalled result holds
  `MCTH_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                    "stalled result changed")

endmodule

bind memory_card_three_wire_host_top mcth_checker u_chk (.*);

`default_nettype wire
